// ----- src/rto_pkg.sv -----
// ----------------------------------------------------------------------------
// rto_pkg
// Shared field widths, opcodes, register indexes and reset values of the
// retransmission timeout estimator.
// ----------------------------------------------------------------------------
package rto_pkg;

    localparam int FIELD_W   = 20;
    localparam int OPCODE_W  = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE  = 2'd0,
        OP_BACKOFF = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd2;

    localparam int RST_INITIAL = 3000;
    localparam int RST_FLOOR   = 1000;
    localparam int RST_CEILING = 60000;

endpackage

// ----- src/rto_update.sv -----
// ----------------------------------------------------------------------------
// rto_update
// Next estimator state for one operation: sample smoothing, backoff
// doubling, restart; sample timeout clamped to floor and ceiling, backoff to ceiling.
// ----------------------------------------------------------------------------
module rto_update
    import rto_pkg::*;
#(
    parameter int TIME_WIDTH = 20
) (
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [TIME_WIDTH-1:0] i_rtt,
    input  logic [TIME_WIDTH-1:0] i_srtt,
    input  logic [TIME_WIDTH-1:0] i_rttvar,
    input  logic [TIME_WIDTH-1:0] i_rto,
    input  logic                  i_has_meas,
    input  logic [TIME_WIDTH-1:0] i_initial,
    input  logic [TIME_WIDTH-1:0] i_floor,
    input  logic [TIME_WIDTH-1:0] i_ceiling,
    output logic [TIME_WIDTH-1:0] o_srtt,
    output logic [TIME_WIDTH-1:0] o_rttvar,
    output logic [TIME_WIDTH-1:0] o_rto,
    output logic                  o_has_meas
);

    localparam int SUM_W = TIME_WIDTH + 3;

    logic [TIME_WIDTH-1:0] w_diff;
    logic [TIME_WIDTH-1:0] w_srtt_smooth;
    logic [TIME_WIDTH-1:0] w_var_smooth;
    logic [TIME_WIDTH-1:0] w_srtt_s;
    logic [TIME_WIDTH-1:0] w_var_s;
    logic [SUM_W-1:0]      w_sum;
    logic [SUM_W-1:0]      w_sum_floor;
    logic [TIME_WIDTH-1:0] w_rto_sample;
    logic [TIME_WIDTH:0]   w_double;
    logic [TIME_WIDTH-1:0] w_rto_backoff;

    always_comb begin
        w_diff        = (i_srtt >= i_rtt) ? (i_srtt - i_rtt) : (i_rtt - i_srtt);
        w_var_smooth  = i_rttvar - (i_rttvar >> 2) + (w_diff >> 2);
        w_srtt_smooth = i_srtt - (i_srtt >> 3) + (i_rtt >> 3);

        if (i_has_meas) begin
            w_srtt_s = w_srtt_smooth;
            w_var_s  = w_var_smooth;
        end else begin
            w_srtt_s = i_rtt;
            w_var_s  = i_rtt >> 1;
        end

        // floor first, ceiling last: the ceiling wins when they cross
        w_sum       = SUM_W'(w_srtt_s) + {1'b0, w_var_s, 2'b00};
        w_sum_floor = (w_sum < SUM_W'(i_floor)) ? SUM_W'(i_floor) : w_sum;
        w_rto_sample = (w_sum_floor > SUM_W'(i_ceiling)) ? i_ceiling
                                                         : w_sum_floor[TIME_WIDTH-1:0];

        w_double      = {i_rto, 1'b0};
        w_rto_backoff = (w_double > {1'b0, i_ceiling}) ? i_ceiling
                                                       : w_double[TIME_WIDTH-1:0];
    end

    always_comb begin
        o_srtt     = i_srtt;
        o_rttvar   = i_rttvar;
        o_rto      = i_rto;
        o_has_meas = i_has_meas;
        case (t_opcode'(i_opcode))
            OP_SAMPLE: begin
                o_srtt     = w_srtt_s;
                o_rttvar   = w_var_s;
                o_rto      = w_rto_sample;
                o_has_meas = 1'b1;
            end
            OP_BACKOFF: begin
                o_rto = w_rto_backoff;
            end
            OP_RESTART: begin
                o_rto      = i_initial;
                o_has_meas = 1'b0;
            end
            default: begin
                // unused code: hold everything
                o_rto = i_rto;
            end
        endcase
    end

endmodule

// ----- src/tcp_retransmit_timeout_estimator.sv -----
// ----------------------------------------------------------------------------
// tcp_retransmit_timeout_estimator
// Retransmission timeout estimator: smoothed RTT, RTT variation and timeout
// updated per operation, one result item per input item.
// ----------------------------------------------------------------------------
//  channel   valid     stall     payload
//  input     i_valid   o_stall   i_opcode, i_round_trip_ms
//  output    o_valid   i_stall   o_timeout_ms, o_smoothed_rtt_ms, o_rtt_variation_ms
//  config    i_cfg_we  -         i_cfg_addr, i_cfg_wdata
//
//  One item per cycle sustained while i_stall stays low; o_valid rises once
//  the item has passed the input register, then the result register.
//  The estimator state updates as an item moves from the input register into
//  the result register, so each item sees the state its predecessor left.
//  A stalled result holds; the input register fills behind it, then o_stall.
//  Reset (synchronous) empties both registers and loads default config.
// ----------------------------------------------------------------------------
module tcp_retransmit_timeout_estimator
    import rto_pkg::*;
#(
    parameter int TIME_WIDTH = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [TIME_WIDTH-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [FIELD_W-1:0]    i_round_trip_ms,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [FIELD_W-1:0]    o_timeout_ms,
    output logic [FIELD_W-1:0]    o_smoothed_rtt_ms,
    output logic [FIELD_W-1:0]    o_rtt_variation_ms
);

    logic [TIME_WIDTH-1:0] r_initial;
    logic [TIME_WIDTH-1:0] r_floor;
    logic [TIME_WIDTH-1:0] r_ceiling;

    logic [TIME_WIDTH-1:0] r_srtt;
    logic [TIME_WIDTH-1:0] r_rttvar;
    logic [TIME_WIDTH-1:0] r_rto;
    logic                  r_has_meas;

    logic                  r_in_valid;
    logic [OPCODE_W-1:0]   r_in_opcode;
    logic [TIME_WIDTH-1:0] r_in_rtt;

    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_out_timeout;
    logic [FIELD_W-1:0]    r_out_srtt;
    logic [FIELD_W-1:0]    r_out_rttvar;

    logic [TIME_WIDTH-1:0] n_srtt;
    logic [TIME_WIDTH-1:0] n_rttvar;
    logic [TIME_WIDTH-1:0] n_rto;
    logic                  n_has_meas;

    logic                  w_advance;
    logic                  w_in_take;

    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_in_take = i_valid && !o_stall;

    rto_update #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_update (
        .i_opcode  (r_in_opcode),
        .i_rtt     (r_in_rtt),
        .i_srtt    (r_srtt),
        .i_rttvar  (r_rttvar),
        .i_rto     (r_rto),
        .i_has_meas(r_has_meas),
        .i_initial (r_initial),
        .i_floor   (r_floor),
        .i_ceiling (r_ceiling),
        .o_srtt    (n_srtt),
        .o_rttvar  (n_rttvar),
        .o_rto     (n_rto),
        .o_has_meas(n_has_meas)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial <= TIME_WIDTH'(RST_INITIAL);
            r_floor   <= TIME_WIDTH'(RST_FLOOR);
            r_ceiling <= TIME_WIDTH'(RST_CEILING);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_INITIAL: r_initial <= i_cfg_wdata;
                CFG_FLOOR:   r_floor   <= i_cfg_wdata;
                CFG_CEILING: r_ceiling <= i_cfg_wdata;
                default:     r_initial <= r_initial;
            endcase
        end
    end

    // estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srtt     <= '0;
            r_rttvar   <= '0;
            r_rto      <= TIME_WIDTH'(RST_INITIAL);
            r_has_meas <= 1'b0;
        end else if (w_advance) begin
            r_srtt     <= n_srtt;
            r_rttvar   <= n_rttvar;
            r_rto      <= n_rto;
            r_has_meas <= n_has_meas;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_opcode <= i_opcode;
            r_in_rtt    <= TIME_WIDTH'(i_round_trip_ms);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_timeout <= FIELD_W'(n_rto);
            r_out_srtt    <= FIELD_W'(n_srtt);
            r_out_rttvar  <= FIELD_W'(n_rttvar);
        end
    end

    assign o_valid            = r_out_valid;
    assign o_timeout_ms       = r_out_timeout;
    assign o_smoothed_rtt_ms  = r_out_srtt;
    assign o_rtt_variation_ms = r_out_rttvar;

endmodule

// ----- src/rto_checker.sv -----
// ----------------------------------------------------------------------------
// rto_checker
// Port-level checks of the estimator's handshakes and item timing.
// ----------------------------------------------------------------------------
module rto_checker
    import rto_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [FIELD_W-1:0]   o_timeout_ms,
    input logic [FIELD_W-1:0]   o_smoothed_rtt_ms,
    input logic [FIELD_W-1:0]   o_rtt_variation_ms
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_timeout_ms)
            && $stable(o_smoothed_rtt_ms) && $stable(o_rtt_variation_ms))
        else $error("stalled result item changed");

    // input backs up only behind a stalled, full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output free");

    // a new result follows an item taken at the input
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result item without accepted input item");

    // reset empties the block
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not empty after reset");

endmodule

bind tcp_retransmit_timeout_estimator rto_checker u_rto_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_timeout_ms      (o_timeout_ms),
    .o_smoothed_rtt_ms (o_smoothed_rtt_ms),
    .o_rtt_variation_ms(o_rtt_variation_ms)
);
